### rtl/tftr_pkg.sv
// Types and constants for the transfer function table resampler.
package tftr_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_KEYS = 2'd1;
    localparam logic [1:0] STATUS_BAD_BIN = 2'd2;

    localparam int POS_W   = 17;
    localparam int CHAN_W  = 16;
    localparam int COLOR_W = 64;
    localparam logic [POS_W-1:0] MIN_GAP = 17'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [16:0] intensity;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [15:0] alpha_in;
        logic [9:0]  bin_index;
    } in_item_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] alpha_out;
        logic [1:0]  status;
    } out_item_t;

    // Search token that walks down the key chain.
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [POS_W-1:0]     pos;
        logic [POS_W-1:0]     prev_pos;
        logic [COLOR_W-1:0]   prev_color;
        logic [POS_W-1:0]     hit_pos;
        logic [COLOR_W-1:0]   hit_color;
        logic                 first;
    } search_t;

endpackage

### rtl/transfer_function_table_resampler.sv
// Top level: key chain search, then per-channel interpolation with a shared divider.
// The bin position is placed with the divider and the key search walks the whole chain; then
// per channel come a multiply, a divider start, 34 divide steps and a capture. A bin whose
// colour is taken as is from a key skips the channel steps; a rejected bin is answered from idle.
// One transaction at a time: s_ready stays low until the result is taken.
// Reset: synchronous active-low aresetn empties the key chain and sets bins_reg to 256.
module transfer_function_table_resampler #(
    parameter int MAX_KEYS = 32,
    parameter int MAX_BINS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tftr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tftr_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [10:0]         cfg_data
);

    localparam int KW = $clog2(MAX_KEYS + 1);
    localparam int PW = tftr_pkg::POS_W;
    localparam int CW = tftr_pkg::CHAN_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POS  = 3'd1;
    localparam logic [2:0] ST_SRCH = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_GO   = 3'd6;

    logic [2:0]          state_reg;
    logic [10:0]         bins_reg;
    logic [KW-1:0]       count_reg;
    logic [KW-1:0]       walk_reg;
    logic [1:0]          ch_reg;
    tftr_pkg::out_item_t out_reg;
    tftr_pkg::search_t   res_reg;
    logic [PW-1:0]       u_reg;
    logic [PW-1:0]       g_reg;
    logic [33:0]         num_reg;

    logic [10:0] nb;
    always_comb begin
        nb = bins_reg;
        if (nb < 11'd2) nb = 11'd2;
        if (32'(nb) > MAX_BINS) nb = 11'(MAX_BINS);
    end

    logic accept;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid;
    assign accept  = s_valid && s_ready;

    // key chain
    tftr_pkg::search_t tok [MAX_KEYS+1];
    logic               tok_start;
    logic [PW-1:0]      pos_val;
    logic               clear_keys;

    assign clear_keys = accept && s_data.cmd == tftr_pkg::CMD_CLEAR;

    always_comb begin
        tok[0]            = '0;
        tok[0].valid      = tok_start;
        tok[0].pos        = pos_val;
        tok[0].first      = 1'b1;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEYS; gi++) begin : g_cell
            tftr_key_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .clear     (clear_keys),
                .load      (accept && s_data.cmd == tftr_pkg::CMD_APPEND
                            && 32'(count_reg) == gi),
                .load_pos  (s_data.intensity),
                .load_color({s_data.alpha_in, s_data.blue_in,
                             s_data.green_in, s_data.red_in}),
                .tok_in    (tok[gi]),
                .tok_out   (tok[gi+1])
            );
        end
    endgenerate

    // shared divider: bin position first, then channel interpolation
    logic        div_start;
    logic [33:0] div_num;
    logic [16:0] div_den;
    logic        div_done;
    logic [33:0] div_q;

    tftr_divider #(.NUM_W(34), .DEN_W(17)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .numer  (div_num),
        .denom  (div_den),
        .done   (div_done),
        .quot   (div_q)
    );

    assign pos_val = div_q[PW-1:0];

    logic [CW-1:0] c0, c1;
    assign c0 = res_reg.prev_color[ch_reg*CW +: CW];
    assign c1 = res_reg.hit_color[ch_reg*CW +: CW];

    logic [32:0] prod0, prod1;
    assign prod0 = c0 * (g_reg - u_reg);
    assign prod1 = c1 * u_reg;

    always_comb begin
        div_start = 1'b0;
        div_num   = num_reg;
        div_den   = g_reg;
        if (accept && s_data.cmd == tftr_pkg::CMD_EVAL && s_data.bin_index < nb
            && count_reg != '0) begin
            div_start = 1'b1;
            div_num   = {8'd0, s_data.bin_index, 16'd0};
            div_den   = 17'(nb - 11'd1);
        end else if (state_reg == ST_GO) begin
            div_start = 1'b1;
        end
    end

    assign tok_start = (state_reg == ST_POS) && div_done;

    logic [PW-1:0] gap;
    assign gap = tok[MAX_KEYS].hit_pos - tok[MAX_KEYS].prev_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bins_reg  <= 11'd256;
            count_reg <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (cfg_we) bins_reg <= cfg_data;
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_data.cmd)
                            tftr_pkg::CMD_CLEAR: count_reg <= '0;
                            tftr_pkg::CMD_APPEND: begin
                                if (32'(count_reg) < MAX_KEYS) count_reg <= count_reg + 1'b1;
                            end
                            tftr_pkg::CMD_EVAL: begin
                                if (s_data.bin_index >= nb) begin
                                    out_reg <= {64'd0, tftr_pkg::STATUS_BAD_BIN};
                                    m_valid <= 1'b1;
                                end else if (count_reg == '0) begin
                                    out_reg <= {64'd0, tftr_pkg::STATUS_NO_KEYS};
                                    m_valid <= 1'b1;
                                end else begin
                                    state_reg <= ST_POS;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_POS: begin
                    if (div_done) begin
                        walk_reg  <= '0;
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    walk_reg <= walk_reg + 1'b1;
                    if (32'(walk_reg) == MAX_KEYS - 1) begin
                        res_reg <= tok[MAX_KEYS];
                        u_reg   <= tok[MAX_KEYS].pos - tok[MAX_KEYS].prev_pos;
                        g_reg   <= gap;
                        ch_reg  <= 2'd0;
                        if (!tok[MAX_KEYS].found) begin
                            out_reg <= {tok[MAX_KEYS].prev_color[15:0],
                                        tok[MAX_KEYS].prev_color[31:16],
                                        tok[MAX_KEYS].prev_color[47:32],
                                        tok[MAX_KEYS].prev_color[63:48],
                                        tftr_pkg::STATUS_OK};
                            state_reg <= ST_OUT;
                        end else if (tok[MAX_KEYS].first || gap <= tftr_pkg::MIN_GAP) begin
                            out_reg <= {tok[MAX_KEYS].hit_color[15:0],
                                        tok[MAX_KEYS].hit_color[31:16],
                                        tok[MAX_KEYS].hit_color[47:32],
                                        tok[MAX_KEYS].hit_color[63:48],
                                        tftr_pkg::STATUS_OK};
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_GO;
                end
                ST_GO: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        case (ch_reg)
                            2'd0: out_reg.red_out   <= div_q[CW-1:0];
                            2'd1: out_reg.green_out <= div_q[CW-1:0];
                            2'd2: out_reg.blue_out  <= div_q[CW-1:0];
                            default: out_reg.alpha_out <= div_q[CW-1:0];
                        endcase
                        out_reg.status <= tftr_pkg::STATUS_OK;
                        ch_reg <= ch_reg + 2'd1;
                        state_reg <= (ch_reg == 2'd3) ? ST_OUT : ST_MUL;
                    end
                end
                ST_OUT: begin
                    // fields are loaded in output order red..alpha
                    m_valid   <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // weighted sum for the current channel, registered before the divider
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            num_reg <= {1'b0, prod0} + {1'b0, prod1};
        end
    end

    assign m_data = out_reg;

endmodule

### rtl/tftr_key_cell.sv
// One key slot: holds a key and compares the passing search token.
module tftr_key_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  logic                         load,
    input  logic [tftr_pkg::POS_W-1:0]   load_pos,
    input  logic [tftr_pkg::COLOR_W-1:0] load_color,
    input  tftr_pkg::search_t            tok_in,
    output tftr_pkg::search_t            tok_out
);

    logic                         full_reg;
    logic [tftr_pkg::POS_W-1:0]   pos_reg;
    logic [tftr_pkg::COLOR_W-1:0] color_reg;
    tftr_pkg::search_t            tok_reg;
    tftr_pkg::search_t            tok_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            full_reg <= 1'b0;
        end else if (load) begin
            full_reg <= 1'b1;
        end
        if (load) begin
            pos_reg   <= load_pos;
            color_reg <= load_color;
        end
    end

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found && full_reg) begin
            if (tok_in.pos <= pos_reg) begin
                tok_next.found     = 1'b1;
                tok_next.hit_pos   = pos_reg;
                tok_next.hit_color = color_reg;
            end else begin
                tok_next.first      = 1'b0;
                tok_next.prev_pos   = pos_reg;
                tok_next.prev_color = color_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.found      <= tok_next.found;
        tok_reg.pos        <= tok_next.pos;
        tok_reg.prev_pos   <= tok_next.prev_pos;
        tok_reg.prev_color <= tok_next.prev_color;
        tok_reg.hit_pos    <= tok_next.hit_pos;
        tok_reg.hit_color  <= tok_next.hit_color;
        tok_reg.first      <= tok_next.first;
    end

    assign tok_out = tok_reg;

endmodule

### rtl/tftr_divider.sv
// Restoring divider, one quotient bit per cycle while busy.
module tftr_divider #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   shifted;
    logic             ge;

    assign shifted = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
        if (start) begin
            q_reg   <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (busy_reg) begin
            rem_reg <= ge ? (shifted - {1'b0, den_reg}) : shifted;
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign quot = q_reg;

endmodule

### rtl/tftr_checker.sv
// Port-level checker for the resampler, bound to the top level.
module tftr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input tftr_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input tftr_pkg::out_item_t m_data
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("bad status");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != tftr_pkg::STATUS_OK |->
        m_data.red_out == '0 && m_data.alpha_out == '0)
        else $error("error result carries colour");

    a_no_eval_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd != tftr_pkg::CMD_EVAL && !m_valid |=> !m_valid)
        else $error("result without evaluate");

endmodule

bind transfer_function_table_resampler tftr_checker u_tftr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
